// ===== src/fcsr_pkg.sv =====
// Shared types, constants and the microcode program of the fan curve speed regulator.
package fcsr_pkg;

    localparam int TEMP_W     = 11;
    localparam int RPM_W      = 14;
    localparam int THR_W      = 7;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = RPM_W + THR_W;
    localparam int DIV_DW     = PROD_W;
    localparam int DIV_VW     = 10;
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam int SPEED_STEP_DEF = 100;
    localparam int MAX_SLEW_DEF   = 500;

    localparam logic [RPM_W-1:0] MIN_RPM_RST    = RPM_W'(2000);
    localparam logic [RPM_W-1:0] MAX_RPM_RST    = RPM_W'(6000);
    localparam logic [RPM_W-1:0] MANUAL_RPM_RST = RPM_W'(2000);
    localparam logic [THR_W-1:0] LOWER_RST      = THR_W'(50);
    localparam logic [THR_W-1:0] UPPER_RST      = THR_W'(80);

    localparam logic [1:0] TSRC_CPU = 2'd0;
    localparam logic [1:0] TSRC_GPU = 2'd1;

    typedef logic [RPM_W-1:0]         rpm_t;
    typedef logic [THR_W-1:0]         thr_t;
    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic [STEP_W-1:0]        step_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUAL_MODE,
        CFG_TEMP_SOURCE,
        CFG_MIN_RPM,
        CFG_MAX_RPM,
        CFG_LOWER_THRESH,
        CFG_UPPER_THRESH,
        CFG_MANUAL_RPM,
        CFG_EASING_ENABLE
    } cfg_idx_t;

    typedef struct packed {
        logic       manual_mode;
        logic [1:0] temp_source;
        rpm_t       min_rpm;
        rpm_t       max_rpm;
        thr_t       lower_thresh;
        thr_t       upper_thresh;
        rpm_t       manual_rpm;
        logic       easing_enable;
    } cfg_t;

    typedef struct packed {
        logic write_min;
        rpm_t min_value;
        logic write_max;
        rpm_t max_value;
    } res_t;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_MUL,
        UOP_DIV_CURVE,
        UOP_CURVE,
        UOP_FLAT,
        UOP_ADJ,
        UOP_EASE,
        UOP_DIV_STEP,
        UOP_REM,
        UOP_ROUND,
        UOP_CLAMP,
        UOP_FINISH,
        UOP_MANUAL
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_MANUAL,
        COND_FLAT,
        COND_DIV_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  uop;
        cond_t cond;
        step_t jump;
        logic  done;
    } ctl_t;

    typedef struct packed {
        logic manual;
        logic flat;
        logic div_busy;
    } flags_t;

    // Program addresses
    localparam step_t ST_MUL       = 4'd0;
    localparam step_t ST_DIV_CURVE = 4'd1;
    localparam step_t ST_WAIT_C    = 4'd2;
    localparam step_t ST_CURVE     = 4'd3;
    localparam step_t ST_FLAT      = 4'd4;
    localparam step_t ST_ADJ       = 4'd5;
    localparam step_t ST_EASE      = 4'd6;
    localparam step_t ST_DIV_STEP  = 4'd7;
    localparam step_t ST_REM       = 4'd8;
    localparam step_t ST_ROUND     = 4'd9;
    localparam step_t ST_CLAMP     = 4'd10;
    localparam step_t ST_FINISH    = 4'd11;
    localparam step_t ST_MANUAL    = 4'd12;

    function automatic ctl_t rom_word(input step_t s);
        ctl_t w;
        w = '{uop: UOP_NOP, cond: COND_NEXT, jump: ST_MUL, done: 1'b0};
        unique case (s)
            ST_MUL: begin
                w.uop  = UOP_MUL;
                w.cond = COND_MANUAL;
                w.jump = ST_MANUAL;
            end
            ST_DIV_CURVE: begin
                w.uop  = UOP_DIV_CURVE;
                w.cond = COND_FLAT;
                w.jump = ST_FLAT;
            end
            ST_WAIT_C: begin
                w.cond = COND_DIV_BUSY;
                w.jump = ST_WAIT_C;
            end
            ST_CURVE: begin
                w.uop  = UOP_CURVE;
                w.cond = COND_ALWAYS;
                w.jump = ST_ADJ;
            end
            ST_FLAT:     w.uop = UOP_FLAT;
            ST_ADJ:      w.uop = UOP_ADJ;
            ST_EASE:     w.uop = UOP_EASE;
            ST_DIV_STEP: w.uop = UOP_DIV_STEP;
            ST_REM:      w.uop = UOP_REM;
            ST_ROUND:    w.uop = UOP_ROUND;
            ST_CLAMP:    w.uop = UOP_CLAMP;
            ST_FINISH: begin
                w.uop  = UOP_FINISH;
                w.done = 1'b1;
            end
            ST_MANUAL: begin
                w.uop  = UOP_MANUAL;
                w.done = 1'b1;
            end
            default:     w.done = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ===== src/fcsr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module fcsr_div
    import fcsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_DW-1:0] dividend,
    input  logic [DIV_VW-1:0] divisor,
    output logic [DIV_DW-1:0] quot,
    output logic              busy
);

    localparam int CW = $clog2(DIV_DW + 1);

    logic [CW-1:0]     cnt_reg;
    logic [DIV_DW-1:0] q_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_VW-1:0] div_reg;
    logic [DIV_VW:0]   trial;
    logic [DIV_VW:0]   diff;
    logic              ge;

    assign busy  = (cnt_reg != '0);
    assign trial = {rem_reg, q_reg[DIV_DW-1]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};
    assign quot  = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(DIV_DW);
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy) begin
            q_reg   <= {q_reg[DIV_DW-2:0], ge};
            rem_reg <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
        end
    end

endmodule

// ===== src/fcsr_seq.sv =====
// Microcode sequencer: step counter, program table and conditional jumps.
module fcsr_seq
    import fcsr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   start,
    input  logic   hold,
    input  flags_t flags,
    output ctl_t   ctl,
    output logic   fire,
    output logic   busy
);

    step_t step_reg, step_next;
    logic  running_reg, running_next;
    logic  take;

    assign ctl  = rom_word(step_reg);
    assign busy = running_reg;
    // Stall the last step while the result slot is still occupied
    assign fire = running_reg && !(ctl.done && hold);

    always_comb begin
        unique case (ctl.cond)
            COND_NEXT:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_MANUAL:   take = flags.manual;
            COND_FLAT:     take = flags.flat;
            COND_DIV_BUSY: take = flags.div_busy;
            default:       take = 1'b0;
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        running_next = running_reg;
        if (start) begin
            step_next    = ST_MUL;
            running_next = 1'b1;
        end else if (fire) begin
            step_next = take ? ctl.jump : step_reg + 1'b1;
            if (ctl.done) begin
                running_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_MUL;
            running_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            running_reg <= running_next;
        end
    end

endmodule

// ===== src/fcsr_datapath.sv =====
// Datapath of the regulator: operand registers, multiplier, divider and result logic.
module fcsr_datapath
    import fcsr_pkg::*;
#(
    parameter int SPEED_STEP = SPEED_STEP_DEF,
    parameter int MAX_SLEW   = MAX_SLEW_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [TEMP_W-1:0] cpu_temp,
    input  logic [TEMP_W-1:0] gpu_temp,
    input  rpm_t              rpm_reading,
    input  logic              reading_bad,
    input  logic              fire,
    input  uop_t              uop,
    output flags_t            flags,
    output res_t              res
);

    localparam val_t STEP_V = val_t'(SPEED_STEP);
    localparam val_t HALF_V = val_t'(SPEED_STEP / 2);
    localparam val_t SLEW_V = val_t'(MAX_SLEW);

    localparam int   STEP_SH = RPM_W + $clog2(SPEED_STEP);
    localparam int   RECIP_W = RPM_W + 2;
    localparam int   SPROD_W = RPM_W + RECIP_W;
    // Reciprocal of the speed step, rounded up; exact for every 14-bit dividend
    localparam logic [RECIP_W-1:0] STEP_RECIP =
        RECIP_W'(((64'd1 << STEP_SH) + 64'(SPEED_STEP) - 64'd1) / 64'(SPEED_STEP));

    rpm_t              fan_reg;
    logic [TEMP_W-1:0] t_reg;
    logic [TEMP_W-1:0] t_sel;
    logic [PROD_W-1:0] prod_reg, prod_next;
    val_t              target_reg, target_next;
    rpm_t              fc_reg, fc_next;
    val_t              adj_reg, adj_next;
    rpm_t              step_q_reg, step_q_next;
    val_t              rem_reg, rem_next;
    rpm_t              last_target_reg;

    logic [7:0]         r8;
    thr_t               diff;
    thr_t               span;
    logic               neg;
    rpm_t               mag;
    logic               below, above, empty, flat;
    val_t               mn, mx, fan_v;
    val_t               adj_abs, eased, lim;
    logic               change;
    logic [SPROD_W-1:0] step_prod;

    logic              div_start;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic [DIV_DW-1:0] div_quot;
    logic              div_busy;

    fcsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .busy     (div_busy)
    );

    always_comb begin
        case (cfg.temp_source)
            TSRC_CPU: t_sel = cpu_temp;
            TSRC_GPU: t_sel = gpu_temp;
            default:  t_sel = (cpu_temp > gpu_temp) ? cpu_temp : gpu_temp;
        endcase
    end

    // Curve region and interpolation operands
    assign r8    = 8'((12'(t_reg) + 12'd8) >> 4);
    assign diff  = THR_W'(r8 - 8'(cfg.lower_thresh));
    assign span  = cfg.upper_thresh - cfg.lower_thresh;
    assign neg   = (cfg.max_rpm < cfg.min_rpm);
    assign mag   = neg ? (cfg.min_rpm - cfg.max_rpm) : (cfg.max_rpm - cfg.min_rpm);
    assign below = (t_reg < {cfg.lower_thresh, 4'b0});
    assign above = (t_reg > {cfg.upper_thresh, 4'b0});
    assign empty = (cfg.upper_thresh <= cfg.lower_thresh);
    assign flat  = below || above || empty;

    assign mn    = val_t'(cfg.min_rpm);
    assign mx    = val_t'(cfg.max_rpm);
    assign fan_v = val_t'(fan_reg);

    assign adj_abs = (adj_reg < 0) ? -adj_reg : adj_reg;
    always_comb begin
        if (adj_abs < HALF_V) begin
            eased = '0;
        end else if (adj_reg < -SLEW_V) begin
            eased = -SLEW_V;
        end else if (adj_reg > SLEW_V) begin
            eased = SLEW_V;
        end else begin
            eased = adj_reg;
        end
    end

    assign lim = ((adj_reg <= 0) && (target_reg < mn)) ? mn : target_reg;

    assign change = (target_reg > fan_v + HALF_V) || (target_reg < fan_v - HALF_V) ||
                    (target_reg != val_t'(last_target_reg));

    // Quotient by the speed step through the reciprocal
    assign step_prod = SPROD_W'(target_reg[RPM_W-1:0]) * SPROD_W'(STEP_RECIP);

    assign div_start    = fire && (uop == UOP_DIV_CURVE) && !flat;
    assign div_dividend = prod_reg;
    assign div_divisor  = DIV_VW'(span);

    assign flags = '{manual: cfg.manual_mode, flat: flat, div_busy: div_busy};

    always_comb begin
        prod_next   = prod_reg;
        target_next = target_reg;
        fc_next     = fc_reg;
        adj_next    = adj_reg;
        step_q_next = step_q_reg;
        rem_next    = rem_reg;
        unique case (uop)
            UOP_MUL: begin
                prod_next = PROD_W'(diff) * PROD_W'(mag);
            end
            UOP_CURVE: begin
                target_next = neg ? mn - val_t'(div_quot[RPM_W-1:0])
                                  : mn + val_t'(div_quot[RPM_W-1:0]);
            end
            UOP_FLAT: begin
                target_next = (!below && above) ? mx : mn;
            end
            UOP_ADJ: begin
                // A speed of zero means unknown: take the curve value as current
                fc_next  = (fan_reg == '0) ? target_reg[RPM_W-1:0] : fan_reg;
                adj_next = target_reg - val_t'(fc_next);
            end
            UOP_EASE: begin
                if (cfg.easing_enable) begin
                    adj_next    = eased;
                    target_next = val_t'(fc_reg) + eased;
                end
            end
            UOP_DIV_STEP: begin
                step_q_next = RPM_W'(step_prod >> STEP_SH);
            end
            UOP_REM: begin
                rem_next = target_reg - val_t'(step_q_reg) * STEP_V;
            end
            UOP_ROUND: begin
                // Exact half rounds down
                target_next = target_reg - rem_reg + ((rem_reg > HALF_V) ? STEP_V : val_t'(0));
            end
            UOP_CLAMP: begin
                target_next = (lim > mx) ? mx : lim;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (uop == UOP_MANUAL) begin
            res = '{write_min: 1'b1, min_value: cfg.manual_rpm,
                    write_max: 1'b1, max_value: cfg.manual_rpm};
        end else begin
            res = '{write_min: change,
                    min_value: change ? target_reg[RPM_W-1:0] : '0,
                    write_max: 1'b1,
                    max_value: cfg.max_rpm};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            fan_reg <= reading_bad ? last_target_reg : rpm_reading;
            t_reg   <= t_sel;
        end
        if (fire) begin
            prod_reg   <= prod_next;
            target_reg <= target_next;
            fc_reg     <= fc_next;
            adj_reg    <= adj_next;
            step_q_reg <= step_q_next;
            rem_reg    <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_target_reg <= '0;
        end else if (fire && (uop == UOP_FINISH) && change) begin
            last_target_reg <= target_reg[RPM_W-1:0];
        end
    end

endmodule

// ===== src/fan_curve_speed_regulator_unit.sv =====
// Fan curve speed regulator: an item is taken on s_valid/s_ready and yields one result
// item. In manual mode the result is the manual speed; on the flat parts of the curve
// (below, above or an empty band) the divider is skipped; inside the band the linear
// interpolation waits for the 21-step restoring divider. The rounding to the speed step
// takes a reciprocal multiply and one remainder step. The microcode sequencer works on
// one item at a time; s_ready is low while it runs, and the output register lets a new
// item in while the last result still waits. A finished item holds its last step until
// that waiting result is taken. Configuration writes are taken every cycle and must only
// be issued while the block is idle.
module fan_curve_speed_regulator_unit
    import fcsr_pkg::*;
#(
    parameter int SPEED_STEP = SPEED_STEP_DEF,
    parameter int MAX_SLEW   = MAX_SLEW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [TEMP_W-1:0]     s_cpu_temp,
    input  logic [TEMP_W-1:0]     s_gpu_temp,
    input  logic [RPM_W-1:0]      s_rpm_reading,
    input  logic                  s_reading_bad,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_write_min,
    output logic [RPM_W-1:0]      m_min_value,
    output logic                  m_write_max,
    output logic [RPM_W-1:0]      m_max_value
);

    cfg_t   cfg_reg;
    res_t   res;
    res_t   m_res_reg;
    logic   m_valid_reg;
    ctl_t   ctl;
    flags_t flags;
    logic   fire;
    logic   seq_busy;
    logic   accept;
    logic   load;

    assign cfg_ready = 1'b1;
    assign s_ready   = !seq_busy;
    assign accept    = s_valid && s_ready;
    assign load      = fire && ctl.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{manual_mode: 1'b0, temp_source: TSRC_CPU,
                         min_rpm: MIN_RPM_RST, max_rpm: MAX_RPM_RST,
                         lower_thresh: LOWER_RST, upper_thresh: UPPER_RST,
                         manual_rpm: MANUAL_RPM_RST, easing_enable: 1'b0};
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MANUAL_MODE:   cfg_reg.manual_mode   <= cfg_data[0];
                CFG_TEMP_SOURCE:   cfg_reg.temp_source   <= cfg_data[1:0];
                CFG_MIN_RPM:       cfg_reg.min_rpm       <= cfg_data[RPM_W-1:0];
                CFG_MAX_RPM:       cfg_reg.max_rpm       <= cfg_data[RPM_W-1:0];
                CFG_LOWER_THRESH:  cfg_reg.lower_thresh  <= cfg_data[THR_W-1:0];
                CFG_UPPER_THRESH:  cfg_reg.upper_thresh  <= cfg_data[THR_W-1:0];
                CFG_MANUAL_RPM:    cfg_reg.manual_rpm    <= cfg_data[RPM_W-1:0];
                CFG_EASING_ENABLE: cfg_reg.easing_enable <= cfg_data[0];
            endcase
        end
    end

    fcsr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .hold    (m_valid_reg && !m_ready),
        .flags   (flags),
        .ctl     (ctl),
        .fire    (fire),
        .busy    (seq_busy)
    );

    fcsr_datapath #(
        .SPEED_STEP (SPEED_STEP),
        .MAX_SLEW   (MAX_SLEW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .accept      (accept),
        .cpu_temp    (s_cpu_temp),
        .gpu_temp    (s_gpu_temp),
        .rpm_reading (s_rpm_reading),
        .reading_bad (s_reading_bad),
        .fire        (fire),
        .uop         (ctl.uop),
        .flags       (flags),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_write_min = m_res_reg.write_min;
    assign m_min_value = m_res_reg.min_value;
    assign m_write_max = m_res_reg.write_max;
    assign m_max_value = m_res_reg.max_value;

endmodule

// ===== src/fcsr_checker.sv =====
// Port-level checks of the fan curve speed regulator and their binding.
module fcsr_checker
    import fcsr_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_write_min,
    input logic [RPM_W-1:0] m_min_value,
    input logic             m_write_max,
    input logic [RPM_W-1:0] m_max_value
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_value) && $stable(m_max_value))
        else $error("stalled result changed");

    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_min |-> (m_min_value == '0) && m_write_max)
        else $error("min value set without a write");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_min_value <= m_max_value)
        else $error("min limit above max limit");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("new item taken while one is in work");

endmodule

bind fan_curve_speed_regulator_unit fcsr_checker u_fcsr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_write_min (m_write_min),
    .m_min_value (m_min_value),
    .m_write_max (m_write_max),
    .m_max_value (m_max_value)
);

// ===== test/fan_curve_speed_regulator_unit_tb.sv =====
// Self-checking testbench for the fan curve speed regulator unit.
`timescale 1ns / 1ps

import fcsr_pkg::*;

class fan_limit_tracker;
    logic       manual_mode;
    logic [1:0] temp_source;
    rpm_t       min_rpm;
    rpm_t       max_rpm;
    thr_t       lower_thresh;
    thr_t       upper_thresh;
    rpm_t       manual_rpm;
    logic       easing_enable;
    rpm_t       last_target;
    res_t       expected_limits[$];
    int         mismatches;

    function new();
        manual_mode   = 1'b0;
        temp_source   = TSRC_CPU;
        min_rpm       = MIN_RPM_RST;
        max_rpm       = MAX_RPM_RST;
        lower_thresh  = LOWER_RST;
        upper_thresh  = UPPER_RST;
        manual_rpm    = MANUAL_RPM_RST;
        easing_enable = 1'b0;
        last_target   = '0;
        mismatches    = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MANUAL_MODE:   manual_mode   = data[0];
            CFG_TEMP_SOURCE:   temp_source   = data[1:0];
            CFG_MIN_RPM:       min_rpm       = data[RPM_W-1:0];
            CFG_MAX_RPM:       max_rpm       = data[RPM_W-1:0];
            CFG_LOWER_THRESH:  lower_thresh  = data[THR_W-1:0];
            CFG_UPPER_THRESH:  upper_thresh  = data[THR_W-1:0];
            CFG_MANUAL_RPM:    manual_rpm    = data[RPM_W-1:0];
            CFG_EASING_ENABLE: easing_enable = data[0];
            default: ;
        endcase
    endfunction

    function res_t predict_limits(logic [TEMP_W-1:0] cpu, logic [TEMP_W-1:0] gpu,
                                  logic [RPM_W-1:0] rd, logic bad);
        int   half, fan, fc, t16, tgt, adj, mn, mx, lo, hi, r, d, mag, q, align;
        bit   change;
        res_t res;
        half = SPEED_STEP_DEF / 2;
        if (manual_mode) begin
            res.write_min = 1'b1;
            res.min_value = manual_rpm;
            res.write_max = 1'b1;
            res.max_value = manual_rpm;
            return res;
        end
        fan = bad ? int'(last_target) : int'(rd);
        case (temp_source)
            TSRC_CPU: t16 = int'(cpu);
            TSRC_GPU: t16 = int'(gpu);
            default:  t16 = (cpu > gpu) ? int'(cpu) : int'(gpu);
        endcase
        mn = int'(min_rpm);
        mx = int'(max_rpm);
        lo = int'(lower_thresh);
        hi = int'(upper_thresh);
        if (t16 < lo * 16) begin
            tgt = mn;
        end else if (t16 > hi * 16) begin
            tgt = mx;
        end else if (hi <= lo) begin
            tgt = mn;
        end else begin
            // interpolate from the temperature rounded to whole degrees
            r   = (t16 + 8) >>> 4;
            d   = mx - mn;
            mag = (d < 0) ? -d : d;
            q   = ((r - lo) * mag) / (hi - lo);
            tgt = (d < 0) ? mn - q : mn + q;
        end
        // a zero speed counts as already sitting on the curve
        fc  = (fan == 0) ? tgt : fan;
        adj = tgt - fc;
        if (easing_enable) begin
            mag = (adj < 0) ? -adj : adj;
            if (mag < half) adj = 0;
            else if (adj < -MAX_SLEW_DEF) adj = -MAX_SLEW_DEF;
            else if (adj > MAX_SLEW_DEF) adj = MAX_SLEW_DEF;
            tgt = fc + adj;
        end
        align = tgt % SPEED_STEP_DEF;
        tgt   = tgt - align;
        if (align > half) tgt = tgt + SPEED_STEP_DEF;
        if (adj <= 0 && tgt < mn) tgt = mn;
        if (tgt > mx) tgt = mx;
        change = (tgt > fan + half) || (tgt < fan - half) || (tgt != int'(last_target));
        if (change) begin
            last_target   = rpm_t'(tgt);
            res.write_min = 1'b1;
            res.min_value = last_target;
        end else begin
            res.write_min = 1'b0;
            res.min_value = '0;
        end
        res.write_max = 1'b1;
        res.max_value = max_rpm;
        return res;
    endfunction

    function void note_reading(logic [TEMP_W-1:0] cpu, logic [TEMP_W-1:0] gpu,
                               logic [RPM_W-1:0] rd, logic bad);
        expected_limits.push_back(predict_limits(cpu, gpu, rd, bad));
    endfunction

    function int pending();
        return expected_limits.size();
    endfunction

    function void flag(string what, int exp_val, int act_val);
        mismatches++;
        $display("%0t %s: expected %0d, got %0d", $time, what, exp_val, act_val);
    endfunction

    function void check_limits(res_t got);
        res_t want;
        if (expected_limits.size() == 0) begin
            mismatches++;
            $display("%0t unexpected result item: expected none, got %0d/%0d %0d/%0d", $time,
                     got.write_min, got.min_value, got.write_max, got.max_value);
            return;
        end
        want = expected_limits.pop_front();
        if (got.write_min !== want.write_min)
            flag("write_min", int'(want.write_min), int'(got.write_min));
        if (got.min_value !== want.min_value)
            flag("min_value", int'(want.min_value), int'(got.min_value));
        if (got.write_max !== want.write_max)
            flag("write_max", int'(want.write_max), int'(got.write_max));
        if (got.max_value !== want.max_value)
            flag("max_value", int'(want.max_value), int'(got.max_value));
    endfunction
endclass

module fan_curve_speed_regulator_unit_tb;

    localparam int LIMIT       = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL        = 64;
    localparam int NPHASE      = 14;
    localparam int PHASE_ITEMS = 42;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [TEMP_W-1:0]     s_cpu_temp    = '0;
    logic [TEMP_W-1:0]     s_gpu_temp    = '0;
    logic [RPM_W-1:0]      s_rpm_reading = '0;
    logic                  s_reading_bad = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_write_min;
    logic [RPM_W-1:0]      m_min_value;
    logic                  m_write_max;
    logic [RPM_W-1:0]      m_max_value;

    fan_limit_tracker sb;
    cfg_t cur;
    res_t got;
    bit   tx_quiet  = 1'b0;
    bit   rx_quiet  = 1'b0;
    bit   hold_req  = 1'b0;
    bit   hold_seen = 1'b0;
    bit   ready_next;
    int   hold_left  = 0;
    int   stall_left = 0;
    int   cycles     = 0;

    fan_curve_speed_regulator_unit uut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("fan_curve_speed_regulator_unit: mismatch");
            $finish;
        end
    end

    // result side: check accepted items, then pick next ready
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            got.write_min = m_write_min;
            got.min_value = m_min_value;
            got.write_max = m_write_max;
            got.max_value = m_max_value;
            sb.check_limits(got);
        end
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (rx_quiet || !aresetn) begin
            ready_next = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            ready_next = 1'b0;
        end else begin
            ready_next = 1'b1;
        end
        m_ready <= ready_next;
    end

    task automatic send_item(logic [TEMP_W-1:0] cpu, logic [TEMP_W-1:0] gpu,
                             logic [RPM_W-1:0] rd, logic bad);
        s_valid       <= 1'b1;
        s_cpu_temp    <= cpu;
        s_gpu_temp    <= gpu;
        s_rpm_reading <= rd;
        s_reading_bad <= bad;
        do @(posedge aclk); while (!s_ready);
        sb.note_reading(cpu, gpu, rd, bad);
    endtask

    task automatic idle(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // fill the bits above a register's width with noise
    function automatic logic [CFG_DATA_W-1:0] pad(logic [CFG_DATA_W-1:0] v, int w, bit junk);
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        if (!junk || w >= CFG_DATA_W) return v;
        return v | (noise & ~((CFG_DATA_W'(1) << w) - 1'b1));
    endfunction

    task automatic apply_setting(cfg_t c, bit junk);
        drain();
        write_reg(CFG_MANUAL_MODE, pad(CFG_DATA_W'(c.manual_mode), 1, junk));
        write_reg(CFG_TEMP_SOURCE, pad(CFG_DATA_W'(c.temp_source), 2, junk));
        write_reg(CFG_MIN_RPM, c.min_rpm);
        write_reg(CFG_MAX_RPM, c.max_rpm);
        write_reg(CFG_LOWER_THRESH, pad(CFG_DATA_W'(c.lower_thresh), THR_W, junk));
        write_reg(CFG_UPPER_THRESH, pad(CFG_DATA_W'(c.upper_thresh), THR_W, junk));
        write_reg(CFG_MANUAL_RPM, c.manual_rpm);
        write_reg(CFG_EASING_ENABLE, pad(CFG_DATA_W'(c.easing_enable), 1, junk));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t rand_setting();
        cfg_t c;
        c.manual_mode   = ($urandom_range(0, 5) == 0);
        c.temp_source   = 2'($urandom_range(0, 3));
        c.manual_rpm    = RPM_W'($urandom_range(0, 16383));
        c.easing_enable = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
            c.min_rpm = RPM_W'($urandom_range(0, 4000));
            c.max_rpm = RPM_W'($urandom_range(int'(c.min_rpm), 16383));
        end else begin
            c.min_rpm = RPM_W'($urandom_range(0, 16383));
            c.max_rpm = RPM_W'($urandom_range(0, 16383));
        end
        if ($urandom_range(0, 3) != 0) begin
            c.lower_thresh = THR_W'($urandom_range(0, 100));
            c.upper_thresh = THR_W'($urandom_range(int'(c.lower_thresh), 127));
        end else begin
            c.lower_thresh = THR_W'($urandom_range(0, 127));
            c.upper_thresh = THR_W'($urandom_range(0, 127));
        end
        return c;
    endfunction

    task automatic send_random();
        int a, b, lo16, hi16, near;
        logic [TEMP_W-1:0] t, other;
        logic [RPM_W-1:0]  rd;
        a    = int'(sb.lower_thresh);
        b    = int'(sb.upper_thresh);
        lo16 = ((a < b) ? a : b) * 16 - 24;
        hi16 = ((a < b) ? b : a) * 16 + 40;
        if (lo16 < 0) lo16 = 0;
        if (hi16 > 2047) hi16 = 2047;
        // keep most temperatures around the band so the curve gets exercised
        if ($urandom_range(0, 3) == 0) t = TEMP_W'($urandom_range(0, 2047));
        else t = TEMP_W'($urandom_range(lo16, hi16));
        other = TEMP_W'($urandom_range(0, 2047));
        case ($urandom_range(0, 9))
            0, 1: rd = '0;
            2, 3, 4, 5: begin
                near = int'(sb.last_target) + int'($urandom_range(0, 600)) - 300;
                if (near < 0) near = 0;
                if (near > 16383) near = 16383;
                rd = RPM_W'(near);
            end
            6, 7: rd = RPM_W'($urandom_range(0, 16383));
            default: rd = RPM_W'($urandom_range(int'(sb.min_rpm), int'(sb.max_rpm)));
        endcase
        if ($urandom_range(0, 1))
            send_item(t, other, rd, $urandom_range(0, 4) == 0);
        else
            send_item(other, t, rd, $urandom_range(0, 4) == 0);
    endtask

    initial begin
        cfg_t c;
        bit   gappy;
        sb = new();
        cur.manual_mode   = 1'b0;
        cur.temp_source   = TSRC_CPU;
        cur.min_rpm       = MIN_RPM_RST;
        cur.max_rpm       = MAX_RPM_RST;
        cur.lower_thresh  = LOWER_RST;
        cur.upper_thresh  = UPPER_RST;
        cur.manual_rpm    = MANUAL_RPM_RST;
        cur.easing_enable = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting: thresholds, rounding and the speed reading cases
        send_item(11'd0, 11'd2047, 14'd0, 1'b0);
        send_item(11'd2047, 11'd0, 14'd2000, 1'b0);
        send_item(11'd800, 11'd0, 14'd6000, 1'b0);
        send_item(11'd1280, 11'd0, 14'd0, 1'b0);
        send_item(11'd1281, 11'd0, 14'd5000, 1'b1);
        send_item(11'd1048, 11'd0, 14'd3000, 1'b0);
        send_item(11'd1047, 11'd0, 14'd16383, 1'b0);
        send_item(11'd1000, 11'd0, 14'd16383, 1'b1);
        send_item(11'd1000, 11'd0, 14'd3700, 1'b0);

        cur.temp_source = TSRC_GPU;
        apply_setting(cur, 1'b0);
        send_item(11'd0, 11'd1200, 14'd0, 1'b0);
        send_item(11'd2047, 11'd400, 14'd4000, 1'b0);
        cur.temp_source = 2'd2;
        apply_setting(cur, 1'b0);
        send_item(11'd900, 11'd1100, 14'd0, 1'b0);
        send_item(11'd1100, 11'd900, 14'd0, 1'b0);
        // source three behaves like the larger of both
        cur.temp_source = 2'd3;
        apply_setting(cur, 1'b0);
        send_item(11'd300, 11'd1500, 14'd2500, 1'b0);

        cur.temp_source   = TSRC_CPU;
        cur.easing_enable = 1'b1;
        apply_setting(cur, 1'b0);
        send_item(11'd2047, 11'd0, 14'd2000, 1'b0);
        send_item(11'd0, 11'd0, 14'd6000, 1'b0);
        send_item(11'd1000, 11'd0, 14'd3720, 1'b0);
        send_item(11'd1000, 11'd0, 14'd0, 1'b1);

        cur.manual_mode = 1'b1;
        cur.manual_rpm  = 14'd16383;
        apply_setting(cur, 1'b0);
        send_item(11'd1000, 11'd0, 14'd3000, 1'b0);

        // equal thresholds
        cur.manual_mode   = 1'b0;
        cur.easing_enable = 1'b0;
        cur.lower_thresh  = 7'd60;
        cur.upper_thresh  = 7'd60;
        apply_setting(cur, 1'b0);
        send_item(11'd960, 11'd0, 14'd0, 1'b0);
        send_item(11'd961, 11'd0, 14'd0, 1'b0);

        // lower threshold above the upper one
        cur.lower_thresh = 7'd90;
        cur.upper_thresh = 7'd40;
        apply_setting(cur, 1'b0);
        send_item(11'd1000, 11'd0, 14'd0, 1'b0);
        send_item(11'd1500, 11'd0, 14'd3000, 1'b0);

        // curve running downward
        cur.min_rpm      = 14'd6000;
        cur.max_rpm      = 14'd1000;
        cur.lower_thresh = 7'd50;
        cur.upper_thresh = 7'd80;
        apply_setting(cur, 1'b0);
        send_item(11'd1040, 11'd0, 14'd0, 1'b0);
        send_item(11'd1040, 11'd0, 14'd3000, 1'b0);

        for (int p = 0; p < NPHASE; p++) begin
            c = rand_setting();
            case (p)
                0, 1: begin
                    c.manual_mode   = 1'b0;
                    c.temp_source   = 2'd2;
                    c.min_rpm       = 14'd0;
                    c.max_rpm       = 14'd16383;
                    c.lower_thresh  = 7'd0;
                    c.upper_thresh  = 7'd127;
                    c.easing_enable = (p == 1);
                end
                2: begin
                    c.manual_mode   = 1'b0;
                    c.temp_source   = 2'd3;
                    c.min_rpm       = 14'd16383;
                    c.max_rpm       = 14'd0;
                    c.lower_thresh  = 7'd127;
                    c.upper_thresh  = 7'd0;
                    c.easing_enable = 1'b1;
                end
                3: begin
                    c.manual_mode = 1'b1;
                    c.manual_rpm  = 14'd0;
                end
                6: c.manual_mode = 1'b0;
                default: ;
            endcase
            apply_setting(c, (p >= 4) && $urandom_range(0, 1));
            if (p >= NPHASE - 2) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            gappy = ($urandom_range(0, 2) != 0) && (p != 6);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stall the result side while items keep coming
                if (p == 6 && i == 0) hold_req = 1'b1;
                if (p == 8 && i == PHASE_ITEMS / 2) drain();
                send_random();
                if (!tx_quiet && gappy && $urandom_range(0, 3) == 0)
                    idle($urandom_range(1, 14));
            end
        end

        drain();
        repeat (TAIL) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("fan_curve_speed_regulator_unit: match");
        else
            $display("fan_curve_speed_regulator_unit: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fcsr_pkg.sv
src/fcsr_div.sv
src/fcsr_seq.sv
src/fcsr_datapath.sv
src/fan_curve_speed_regulator_unit.sv
src/fcsr_checker.sv
test/fan_curve_speed_regulator_unit_tb.sv
